### hdl/pcxrle_pkg.sv
// ============================================================================
// pcxrle_pkg
// Shared types and constants of the PCX run-length decoder and blitter.
// ============================================================================
package pcxrle_pkg;

    // Byte classification of the compressed stream.
    localparam logic [7:0] RUN_MARK = 8'hBF;
    localparam logic [7:0] RUN_MASK = 8'h3F;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_BUFFER_WIDTH  = 3'd2;
    localparam logic [2:0] REG_BUFFER_HEIGHT = 3'd3;
    localparam logic [2:0] REG_ORIGIN_X      = 3'd4;
    localparam logic [2:0] REG_ORIGIN_Y      = 3'd5;
    localparam logic [2:0] REG_TRANSPARENT   = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [15:0] IMAGE_WIDTH_RST   = 16'd640;
    localparam logic [15:0] IMAGE_HEIGHT_RST  = 16'd480;
    localparam logic [15:0] BUFFER_WIDTH_RST  = 16'd640;
    localparam logic [15:0] BUFFER_HEIGHT_RST = 16'd480;

    // Command queue between the front and the back.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = 2;

    // Configuration as seen by the pixel generator.
    typedef struct packed {
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] buffer_width;
        logic [15:0] buffer_height;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic        transparent_mode;
    } t_cfg;

    // One command: optional restart, then count copies of value.
    typedef struct packed {
        logic       restart;
        logic [5:0] count;
        logic [7:0] value;
    } t_cmd;

    // Per-pixel attributes carried along the address pipeline.
    typedef struct packed {
        logic [7:0] value;
        logic       clipped;
        logic       write_enable;
        logic       last_of_run;
        logic       image_done;
    } t_pix_meta;

endpackage

### hdl/pcxrle_if.sv
// ============================================================================
// pcxrle channel interfaces
// Valid/ready channels for compressed bytes in and pixel writes out.
// ============================================================================

// Compressed byte channel.
interface pcxrle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// Pixel write channel.
interface pcxrle_out_if #(
    parameter int ADDR_BITS = 24
);
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] pixel_address;
    logic [7:0]           pixel_value;
    logic                 write_enable;
    logic                 last_of_run;
    logic                 image_done;

    modport source (
        output valid, output pixel_address, output pixel_value,
        output write_enable, output last_of_run, output image_done,
        input  ready
    );
    modport sink (
        input  valid, input pixel_address, input pixel_value,
        input  write_enable, input last_of_run, input image_done,
        output ready
    );
endinterface

### hdl/pcxrle_front.sv
// ============================================================================
// pcxrle_front
// Accepts compressed bytes, parses run headers and issues pixel commands.
// ============================================================================
module pcxrle_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pcxrle_in_if.sink         i_byte,
    output pcxrle_pkg::t_cmd  o_cmd,
    output logic              o_push,
    input  logic              i_full
);
    import pcxrle_pkg::*;

    logic       r_awaiting;
    logic [5:0] r_pending;
    logic       n_awaiting;
    logic [5:0] n_pending;
    logic       accept;
    logic       awaiting_e;
    logic [5:0] pending_e;

    // Every byte needs at most one queue slot.
    assign i_byte.ready = !i_full;
    assign accept       = i_byte.valid && !i_full;

    // A frame start clears the parser before the byte is looked at.
    assign awaiting_e = i_byte.frame_start ? 1'b0 : r_awaiting;
    assign pending_e  = i_byte.frame_start ? 6'd0 : r_pending;

    // Classify the byte: run value, run header or literal pixel.
    always_comb begin
        n_awaiting    = r_awaiting;
        n_pending     = r_pending;
        o_push        = 1'b0;
        o_cmd.restart = i_byte.frame_start;
        o_cmd.value   = i_byte.data_byte;
        o_cmd.count   = 6'd0;
        if (accept) begin
            if (awaiting_e) begin
                o_push      = 1'b1;
                o_cmd.count = pending_e;
                n_awaiting  = 1'b0;
                n_pending   = 6'd0;
            end else if (i_byte.data_byte > RUN_MARK) begin
                // A header emits nothing; only a restart has to reach the back.
                n_pending  = i_byte.data_byte[5:0] & RUN_MASK[5:0];
                n_awaiting = (n_pending != 6'd0);
                o_push     = i_byte.frame_start;
            end else begin
                o_push      = 1'b1;
                o_cmd.count = 6'd1;
                n_awaiting  = 1'b0;
                n_pending   = 6'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b0;
            r_pending  <= 6'd0;
        end else begin
            r_awaiting <= n_awaiting;
            r_pending  <= n_pending;
        end
    end

endmodule

### hdl/pcxrle_cmd_fifo.sv
// ============================================================================
// pcxrle_cmd_fifo
// Short command queue that decouples byte parsing from pixel generation.
// ============================================================================
module pcxrle_cmd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pcxrle_pkg::t_cmd  i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output pcxrle_pkg::t_cmd  o_cmd,
    output logic              o_valid
);
    import pcxrle_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_PTR_W:0]   r_count;
    logic                 do_pop;

    assign o_full  = (r_count == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Storage is written only at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if ((i_push && !o_full) && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!(i_push && !o_full) && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hdl/pcxrle_back.sv
// ============================================================================
// pcxrle_back
// Expands commands into pixels, tracks position and computes blit addresses.
// ============================================================================
module pcxrle_back #(
    parameter int ADDR_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcxrle_pkg::t_cfg  i_cfg,
    input  pcxrle_pkg::t_cmd  i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_pop,
    pcxrle_out_if.source      o_pix
);
    import pcxrle_pkg::*;

    localparam int DX_W  = 17;
    localparam int SUM_W = (ADDR_BITS > DX_W) ? ADDR_BITS : DX_W;

    // Position state.
    logic [15:0] r_col, r_row;
    logic        r_fin;
    logic [5:0]  r_cnt;
    logic [15:0] n_col, n_row;
    logic        n_fin;
    logic [5:0]  n_cnt;

    // Pipeline stages: A holds coordinates, B the row product, C is the output.
    logic            r_a_valid, r_b_valid, r_c_valid;
    logic [16:0]     r_a_ysum;
    logic [DX_W-1:0] r_a_dx, r_b_dx;
    t_pix_meta       r_a_meta, r_b_meta, r_c_meta;
    logic [ADDR_BITS-1:0] r_b_prod, r_c_addr;

    logic        adv, step, restart_now, stop, emit, last, done;
    logic        col_end, row_end, clipped;
    logic [15:0] col_e, row_e, vis, img_h, img_w, room;
    logic        fin_e;
    logic [DX_W-1:0] dx;
    logic [16:0] ysum;
    logic [32:0] prod_full;
    logic [SUM_W-1:0] addr_sum;

    // The whole pipeline moves when the output register can take a pixel.
    assign adv  = !r_c_valid || o_pix.ready;
    assign step = i_cmd_valid && adv;

    // Visible rows and effective width from the current configuration.
    always_comb begin
        img_h = (i_cfg.image_height == 16'd0) ? 16'd1 : i_cfg.image_height;
        img_w = (i_cfg.image_width == 16'd0) ? 16'd1 : i_cfg.image_width;
        room  = (i_cfg.buffer_height > i_cfg.origin_y) ?
                (i_cfg.buffer_height - i_cfg.origin_y) : 16'd0;
        vis   = (img_h < room) ? img_h : room;
    end

    // Position as seen by the head command, with a pending restart applied.
    assign restart_now = i_cmd.restart && (r_cnt == 6'd0);
    assign col_e = restart_now ? 16'd0 : r_col;
    assign row_e = restart_now ? 16'd0 : r_row;
    assign fin_e = restart_now ? 1'b0 : r_fin;

    // Pixel classification at the current position.
    always_comb begin
        stop    = fin_e || (row_e >= vis);
        col_end = ({1'b0, col_e} + 17'd1) >= {1'b0, img_w};
        row_end = ({1'b0, row_e} + 17'd1) >= {1'b0, vis};
        done    = col_end && row_end;
        dx      = {1'b0, i_cfg.origin_x} + {1'b0, col_e};
        clipped = dx >= {1'b0, i_cfg.buffer_width};
        ysum    = {1'b0, i_cfg.origin_y} + {1'b0, row_e};
        last    = (r_cnt == (i_cmd.count - 6'd1)) || done;
        emit    = step && (i_cmd.count != 6'd0) && !stop;
        o_pop   = step && ((i_cmd.count == 6'd0) || stop || last);
    end

    // Next position and run progress.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_fin = r_fin;
        n_cnt = r_cnt;
        if (step) begin
            if (i_cmd.count == 6'd0) begin
                // A restart without pixels only clears the position.
                n_col = col_e;
                n_row = row_e;
                n_fin = fin_e;
            end else if (stop) begin
                n_col = col_e;
                n_row = row_e;
                n_fin = 1'b1;
            end else begin
                n_col = col_end ? 16'd0 : (col_e + 16'd1);
                n_row = col_end ? (row_e + 16'd1) : row_e;
                n_fin = done;
            end
            n_cnt = o_pop ? 6'd0 : (r_cnt + 6'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 16'd0;
            r_row <= 16'd0;
            r_fin <= 1'b0;
            r_cnt <= 6'd0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_fin <= n_fin;
            r_cnt <= n_cnt;
        end
    end

    // Valid flags of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= emit;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // Row base multiplication and final address add.
    assign prod_full = 33'(r_a_ysum) * 33'(i_cfg.buffer_width);
    assign addr_sum  = SUM_W'(r_b_prod) + SUM_W'(r_b_dx);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_ysum              <= ysum;
            r_a_dx                <= dx;
            r_a_meta.value        <= i_cmd.value;
            r_a_meta.clipped      <= clipped;
            r_a_meta.write_enable <= !clipped &&
                                     !(i_cfg.transparent_mode && (i_cmd.value == 8'd0));
            r_a_meta.last_of_run  <= last;
            r_a_meta.image_done   <= done;

            r_b_prod <= prod_full[ADDR_BITS-1:0];
            r_b_dx   <= r_a_dx;
            r_b_meta <= r_a_meta;

            r_c_addr <= r_b_meta.clipped ? '0 : addr_sum[ADDR_BITS-1:0];
            r_c_meta <= r_b_meta;
        end
    end

    // Output channel.
    assign o_pix.valid         = r_c_valid;
    assign o_pix.pixel_address = r_c_addr;
    assign o_pix.pixel_value   = r_c_meta.value;
    assign o_pix.write_enable  = r_c_meta.write_enable;
    assign o_pix.last_of_run   = r_c_meta.last_of_run;
    assign o_pix.image_done    = r_c_meta.image_done;

endmodule

### hdl/pcx_rle_decode_blit.sv
// ============================================================================
// pcx_rle_decode_blit
// PCX 8-bit run-length decoder that turns pixels into buffer write requests.
// ============================================================================
// Usage:
// Compressed bytes enter on i_byte (valid/ready). A byte above 0xBF is a run
// header whose low six bits are a repeat count; the following byte is the
// value repeated. Other bytes are single pixels. frame_start on a byte
// restarts at the first pixel before that byte is decoded.
// Each pixel leaves on o_pix as a write request: linear buffer address,
// value, write enable (low for clipped or transparent zero pixels), a flag
// on the last pixel of an input byte, and a flag on the pixel that completes
// the visible image. After that pixel, bytes are dropped until frame_start.
// A pixel passes from its byte through the command queue and registers A, B, C.
// Throughput: one pixel per cycle while the receiver is ready, set by the
// pixel generator of the back end; literal bytes are taken one per cycle
// while the queue has room, a run value byte holds the generator for its
// whole count while the front keeps filling a four-entry command queue.
// Reset clears the decoder position and loads the register defaults (640x480
// image and buffer, origin 0, opaque). A stalled receiver freezes the output
// pipeline; input keeps flowing until the command queue is full. The user is
// to write registers over the APB port only while the block is idle; unchecked.
// ============================================================================
module pcx_rle_decode_blit #(
    parameter int ADDR_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcxrle_in_if.sink   i_byte,
    pcxrle_out_if.source o_pix,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pcxrle_pkg::*;

    t_cfg       r_cfg;
    t_cmd       front_cmd, head_cmd;
    logic       push, full, pop, head_valid;
    logic [2:0] reg_idx;
    logic       wr_en;

    // Register file.
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width      <= IMAGE_WIDTH_RST;
            r_cfg.image_height     <= IMAGE_HEIGHT_RST;
            r_cfg.buffer_width     <= BUFFER_WIDTH_RST;
            r_cfg.buffer_height    <= BUFFER_HEIGHT_RST;
            r_cfg.origin_x         <= 16'd0;
            r_cfg.origin_y         <= 16'd0;
            r_cfg.transparent_mode <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_IMAGE_WIDTH:   r_cfg.image_width      <= pwdata[15:0];
                REG_IMAGE_HEIGHT:  r_cfg.image_height     <= pwdata[15:0];
                REG_BUFFER_WIDTH:  r_cfg.buffer_width     <= pwdata[15:0];
                REG_BUFFER_HEIGHT: r_cfg.buffer_height    <= pwdata[15:0];
                REG_ORIGIN_X:      r_cfg.origin_x         <= pwdata[15:0];
                REG_ORIGIN_Y:      r_cfg.origin_y         <= pwdata[15:0];
                REG_TRANSPARENT:   r_cfg.transparent_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            REG_IMAGE_WIDTH:   prdata = {16'd0, r_cfg.image_width};
            REG_IMAGE_HEIGHT:  prdata = {16'd0, r_cfg.image_height};
            REG_BUFFER_WIDTH:  prdata = {16'd0, r_cfg.buffer_width};
            REG_BUFFER_HEIGHT: prdata = {16'd0, r_cfg.buffer_height};
            REG_ORIGIN_X:      prdata = {16'd0, r_cfg.origin_x};
            REG_ORIGIN_Y:      prdata = {16'd0, r_cfg.origin_y};
            REG_TRANSPARENT:   prdata = {31'd0, r_cfg.transparent_mode};
            default:           prdata = 32'd0;
        endcase
    end

    // Byte parser.
    pcxrle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .o_cmd   (front_cmd),
        .o_push  (push),
        .i_full  (full)
    );

    // Command queue.
    pcxrle_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_valid (head_valid)
    );

    // Pixel generator and address pipeline.
    pcxrle_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (head_cmd),
        .i_cmd_valid (head_valid),
        .o_pop       (pop),
        .o_pix       (o_pix)
    );

endmodule

### tb/pcx_blit_tb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pcx_blit_tb_pkg
// Pixel write predictor and checker for the PCX run-length blitter bench.
// It tracks the decoder position and register copy to predict every
// pixel write, then compares each observed write against the oldest one.
// ============================================================================
package pcx_blit_tb_pkg;

    import pcxrle_pkg::*;

    localparam int PIX_ADDR_BITS = 24;

    // One pixel write request as seen on the output channel.
    typedef struct packed {
        logic [PIX_ADDR_BITS-1:0] addr;
        logic [7:0]               value;
        logic                     we;
        logic                     last;
        logic                     done;
    } t_pix_write;

    class blit_write_predictor;

        t_cfg        cfg;
        bit          awaiting_value;
        bit [5:0]    pending_count;
        bit [15:0]   column;
        bit [15:0]   row;
        bit          finished;
        t_pix_write  expected_q[$];
        int unsigned mismatches;

        // Register defaults and a cleared decoder position.
        function new();
            cfg.image_width      = IMAGE_WIDTH_RST;
            cfg.image_height     = IMAGE_HEIGHT_RST;
            cfg.buffer_width     = BUFFER_WIDTH_RST;
            cfg.buffer_height    = BUFFER_HEIGHT_RST;
            cfg.origin_x         = '0;
            cfg.origin_y         = '0;
            cfg.transparent_mode = 1'b0;
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            awaiting_value = 1'b0;
            pending_count  = '0;
            column         = '0;
            row            = '0;
            finished       = 1'b0;
        endfunction

        // Mirrors a register write accepted on the APB port.
        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                REG_IMAGE_WIDTH:   cfg.image_width      = val;
                REG_IMAGE_HEIGHT:  cfg.image_height     = val;
                REG_BUFFER_WIDTH:  cfg.buffer_width     = val;
                REG_BUFFER_HEIGHT: cfg.buffer_height    = val;
                REG_ORIGIN_X:      cfg.origin_x         = val;
                REG_ORIGIN_Y:      cfg.origin_y         = val;
                REG_TRANSPARENT:   cfg.transparent_mode = val[0];
                default: ;
            endcase
        endfunction

        // Rows of the image that land inside the buffer.
        function int unsigned visible_rows();
            int unsigned h;
            int unsigned room;
            h    = (cfg.image_height == 0) ? 1 : cfg.image_height;
            room = (cfg.buffer_height > cfg.origin_y) ?
                   cfg.buffer_height - cfg.origin_y : 0;
            return (h < room) ? h : room;
        endfunction

        // Predicts one pixel at the current position; returns 0 if none.
        function bit place_pixel(logic [7:0] value);
            int unsigned       vis;
            int unsigned       w;
            int unsigned       dx;
            longint unsigned   top;
            longint unsigned   addr;
            bit                clipped;
            bit                done;
            t_pix_write        p;
            vis = visible_rows();
            w   = (cfg.image_width == 0) ? 1 : cfg.image_width;
            if (finished || row >= vis) begin
                finished = 1'b1;
                return 1'b0;
            end
            dx      = cfg.origin_x + column;
            clipped = dx >= cfg.buffer_width;
            top     = cfg.origin_y;
            addr    = (top + row) * cfg.buffer_width + dx;
            done    = (column + 1 >= w) && (row + 1 >= vis);

            p.addr  = clipped ? '0 : addr[PIX_ADDR_BITS-1:0];
            p.value = value;
            p.we    = !clipped && !(cfg.transparent_mode && value == 8'h00);
            p.last  = 1'b0;
            p.done  = done;
            expected_q.push_back(p);

            // Advance, wrapping to the next row at the image edge.
            if (column + 1 >= w) begin
                column = '0;
                row    = row + 1'b1;
            end else begin
                column = column + 1'b1;
            end
            if (done)
                finished = 1'b1;
            return 1'b1;
        endfunction

        // Works out the pixel writes caused by one accepted input byte.
        function void note_byte(logic [7:0] b, logic fs);
            int n;
            int i;
            t_pix_write tail;
            n = 0;
            if (fs)
                restart();
            if (finished)
                return;
            if (awaiting_value) begin
                awaiting_value = 1'b0;
                for (i = 0; i < pending_count; i++) begin
                    if (!place_pixel(b))
                        break;
                    n++;
                    if (finished)
                        break;
                end
                pending_count = '0;
            end else if (b > RUN_MARK) begin
                pending_count  = b & RUN_MASK;
                awaiting_value = (pending_count != 0);
            end else begin
                n = place_pixel(b);
            end
            // The final write of this byte carries the end-of-run flag.
            if (n > 0) begin
                tail      = expected_q.pop_back();
                tail.last = 1'b1;
                expected_q.push_back(tail);
            end
        endfunction

        function void compare(string field, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
                mismatches++;
            end
        endfunction

        // Checks one observed pixel write against the oldest prediction.
        function void check_pixel(t_pix_write got);
            t_pix_write want;
            if (expected_q.size() == 0) begin
                $display("%0t ns: pixel write with none expected, expected nothing, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            compare("pixel_address", want.addr, got.addr);
            compare("pixel_value", want.value, got.value);
            compare("write_enable", want.we, got.we);
            compare("last_of_run", want.last, got.last);
            compare("image_done", want.done, got.done);
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

    endclass

endpackage

### tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives compressed PCX bytes into pcx_rle_decode_blit and checks every
// pixel write against a predictor, across several register settings,
// random idling on both channels and one long output stall.
// ============================================================================
module testbench;

    import pcxrle_pkg::*;
    import pcx_blit_tb_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;

    // Opening items: frame_start in bit 8, byte in bits 7:0.
    localparam logic [8:0] OPENING_ITEMS [16] = '{
        9'h100, 9'h0BF, 9'h0C0, 9'h001, 9'h0C3, 9'h000, 9'h0FF, 9'h0FF,
        9'h012, 9'h0C2, 9'h1C4, 9'h1C2, 9'h080, 9'h07F, 9'h0C1, 9'h0C5
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned useful_items;
    int unsigned offered_items;
    bit          hold_req = 1'b0;

    blit_write_predictor predicted = new();

    pcxrle_in_if byte_if ();
    pcxrle_out_if #(.ADDR_BITS(PIX_ADDR_BITS)) pix_if ();

    pcx_rle_decode_blit #(.ADDR_BITS(PIX_ADDR_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_pix   (pix_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Output receiver: random stalls, or one long hold when requested.
    initial begin : receiver
        pix_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pix_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                pix_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Every accepted pixel write is checked against the predictor.
    always @(posedge i_clk) begin : pixel_monitor
        t_pix_write seen;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            seen.addr  = pix_if.pixel_address;
            seen.value = pix_if.pixel_value;
            seen.we    = pix_if.write_enable;
            seen.last  = pix_if.last_of_run;
            seen.done  = pix_if.image_done;
            predicted.check_pixel(seen);
        end
    end

    // Watchdog on cycles without any item moving on either channel.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (byte_if.valid && byte_if.ready) ||
                (pix_if.valid && pix_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("testbench: FAIL");
        $finish;
    end

    // Offers one item and waits until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        offered_items++;
        if (fs || !predicted.finished)
            useful_items++;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_if.valid       <= 1'b1;
        byte_if.data_byte   <= b;
        byte_if.frame_start <= fs;
        do @(posedge i_clk); while (!byte_if.ready);
        predicted.note_byte(b, fs);
    endtask

    // APB write: setup cycle, then access cycle.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        predicted.set_reg(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] iw, input logic [15:0] ih,
                             input logic [15:0] bw, input logic [15:0] bh,
                             input logic [15:0] ox, input logic [15:0] oy,
                             input logic tr);
        write_reg(REG_IMAGE_WIDTH, iw);
        write_reg(REG_IMAGE_HEIGHT, ih);
        write_reg(REG_BUFFER_WIDTH, bw);
        write_reg(REG_BUFFER_HEIGHT, bh);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_TRANSPARENT, {15'h0000, tr});
    endtask

    // Stops offering items and waits until the block has gone quiet.
    task automatic settle();
        @(negedge i_clk);
        byte_if.valid <= 1'b0;
        while (predicted.outstanding() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A pixel byte up to top, with zero weighted for transparency.
    function automatic logic [7:0] pixel_byte(int unsigned top);
        return ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(top));
    endfunction

    // Mostly well-formed literal and run items, with some noise and a
    // fresh frame whenever the image has completed.
    task automatic random_stream(input int unsigned target);
        int unsigned start_useful;
        int unsigned start_offered;
        int unsigned pick;
        logic        restart;
        start_useful  = useful_items;
        start_offered = offered_items;
        while (useful_items - start_useful < target &&
               offered_items - start_offered < 4 * target) begin
            pick    = $urandom_range(99);
            restart = predicted.finished || ($urandom_range(99) < 3);
            if (pick < 60) begin
                send_byte(pixel_byte(8'hBF), restart);
            end else if (pick < 92) begin
                send_byte(8'($urandom_range(255, 192)), restart);
                send_byte(pixel_byte(8'hFF), 1'b0);
            end else begin
                send_byte(8'($urandom()), ($urandom_range(7) == 0));
            end
        end
    endtask

    // Main sequence.
    initial begin : stimulus
        int k;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        byte_if.valid       = 1'b0;
        byte_if.data_byte   = '0;
        byte_if.frame_start = 1'b0;
        useful_items        = 0;
        offered_items       = 0;
        send_idle_pct       = 32;
        recv_idle_pct       = 78;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Small clipped, transparent image: literals, zero-count header,
        // image completion mid-run, ignored bytes, restart on a value byte.
        configure(16'd4, 16'd3, 16'd6, 16'd5, 16'd3, 16'd1, 1'b1);
        for (k = 0; k < 16; k++)
            send_byte(OPENING_ITEMS[k][7:0], OPENING_ITEMS[k][8]);
        settle();

        // Clipping at the right edge, then a frame left part way through.
        configure(16'd17, 16'd6, 16'd20, 16'd12, 16'd10, 16'd4, 1'b0);
        random_stream(25);
        for (k = 0; k < 12; k++)
            send_byte(8'($urandom_range(191)), (k == 0));
        settle();

        // Narrower image while the column is already past its new edge.
        write_reg(REG_IMAGE_WIDTH, 16'd5);
        random_stream(20);
        settle();

        send_idle_pct = 78;
        recv_idle_pct = 32;

        // Zero image size behaves as a single pixel.
        configure(16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 1'b1);
        random_stream(15);
        settle();

        // Largest sizes: address wrap and clipping beyond the edge.
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'd300, 1'b0);
        random_stream(25);
        settle();

        // Origin below the buffer: no visible rows at all.
        configure(16'd8, 16'd4, 16'd16, 16'd1, 16'hFFFF, 16'hFFFF, 1'b0);
        random_stream(8);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Receiver holds off while items keep coming, filling the block.
        configure(16'd64, 16'd40, 16'd100, 16'd30, 16'd50, 16'd2, 1'b1);
        hold_req = 1'b1;
        random_stream(35);
        settle();

        if (predicted.mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

### filelist.f
hdl/pcxrle_pkg.sv
hdl/pcxrle_if.sv
hdl/pcxrle_front.sv
hdl/pcxrle_cmd_fifo.sv
hdl/pcxrle_back.sv
hdl/pcx_rle_decode_blit.sv
tb/pcx_blit_tb_pkg.sv
tb/testbench.sv
